>>> src/ovn_pkg.sv
package ovn_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RDA,
    ST_RDB,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } ovn_state_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic done;
    logic int_valid;
    logic int_bit;
  } ovn_div_stat_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic push_bit;
    logic load;
    logic advance;
  } ovn_phase_ctrl_t;

  function automatic logic [3:0] floor_log2_16(input logic [15:0] f);
    logic [3:0] r;
    r = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (f[k]) begin
        r = 4'(k);
      end
    end
    return r;
  endfunction

endpackage

>>> src/octave_value_noise_unit.sv
// Channel   Handshake                 Payload
// command   start / busy              command, entry_index, entry_value, position
// result    done (one-cycle strobe)   noise_sum
// config    cfg_valid / cfg_ready     cfg_data (base_frequency)
//
// Load: table written at the accepting edge, no result.
// Evaluate: the 32-step bit-serial divider runs and hands off its quotient, then
// for each octave the RDA, RDB, MUL and ACC states read two entries through the
// single table read port and accumulate; done follows the last octave.
// With fewer than two as frequency: no division, result 0.
// busy stays high until done has been shown. Reset is synchronous and clears
// control state only; table entries are undefined until loaded.
// The receiver cannot stall: each result is on noise_sum for the done cycle.
module octave_value_noise_unit #(
  parameter int TABLE_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [7:0]  entry_index,
  input  logic [15:0] entry_value,
  input  logic [31:0] position,
  output logic        done,
  output logic [16:0] noise_sum,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import ovn_pkg::*;

  localparam int AW = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;

  ovn_state_t      state, state_next;
  logic [15:0]     base_frequency;
  logic [3:0]      octaves;
  logic [3:0]      oct;
  logic [16:0]     sum;
  logic [15:0]     a_val;
  logic signed [33:0] prod;

  logic            accept;
  logic            table_we;
  logic [AW-1:0]   raddr;
  logic [15:0]     rdata;
  logic            div_start;
  ovn_div_stat_t   div_stat;
  logic [31:0]     quotient;
  ovn_phase_ctrl_t phase_ctrl;
  logic [AW-1:0]   idx, nxt;
  logic [15:0]     frac;
  logic [3:0]      cur_octaves;

  logic signed [16:0] diff;
  logic signed [17:0] interp_w;
  logic [15:0]        interp;

  assign accept      = start & ~busy;
  assign cfg_ready   = 1'b1;
  assign cur_octaves = floor_log2_16(base_frequency);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frequency <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      base_frequency <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && command == CMD_EVAL) begin
          state_next = (cur_octaves == 4'd0) ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_RDA;
        end
      end
      ST_RDA: state_next = ST_RDB;
      ST_RDB: state_next = ST_MUL;
      ST_MUL: state_next = ST_ACC;
      ST_ACC: state_next = (oct == octaves - 4'd1) ? ST_OUT : ST_RDA;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy                = (state != ST_IDLE);
    done                = (state == ST_OUT);
    div_start           = 1'b0;
    table_we            = 1'b0;
    raddr               = idx;
    phase_ctrl          = '0;
    phase_ctrl.push_bit = div_stat.int_bit;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_LOAD) begin
            table_we = {24'd0, entry_index} < 32'(TABLE_SIZE);
          end else begin
            div_start        = (cur_octaves != 4'd0);
            phase_ctrl.clear = 1'b1;
          end
        end
      end
      ST_DIV: begin
        phase_ctrl.push = div_stat.int_valid;
        phase_ctrl.load = div_stat.done;
      end
      ST_RDA: raddr = idx;
      ST_RDB: raddr = nxt;
      ST_ACC: phase_ctrl.advance = 1'b1;
      default: ;
    endcase
  end

  // interp = a + floor(frac * (b - a) / 2^16)
  assign diff     = $signed({1'b0, rdata}) - $signed({1'b0, a_val});
  assign interp_w = $signed({2'b00, a_val}) + prod[33:16];
  assign interp   = interp_w[15:0];

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sum     <= '0;
        oct     <= '0;
        octaves <= cur_octaves;
      end
      ST_RDB: a_val <= rdata;
      ST_MUL: prod  <= diff * $signed({1'b0, frac});
      ST_ACC: begin
        sum <= sum + 17'(interp >> oct);
        oct <= oct + 4'd1;
      end
      default: ;
    endcase
  end

  assign noise_sum = sum;

  ovn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (position),
    .divisor  (base_frequency),
    .stat     (div_stat),
    .quotient (quotient)
  );

  ovn_phase #(
    .TABLE_SIZE (TABLE_SIZE),
    .AW         (AW)
  ) u_phase (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (phase_ctrl),
    .frac_in (quotient[15:0]),
    .idx     (idx),
    .nxt     (nxt),
    .frac    (frac)
  );

  ovn_table #(
    .TABLE_SIZE (TABLE_SIZE),
    .AW         (AW)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .waddr (AW'(entry_index)),
    .wdata (entry_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a transaction");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_LOAD) |=> !busy)
    else $error("load transaction left the unit busy");

  a_no_octave: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_EVAL && cur_octaves == 4'd0) |=> (done && noise_sum == 17'd0))
    else $error("zero-octave evaluate did not return zero");

  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> noise_sum <= 17'd131070)
    else $error("noise sum out of range");

endmodule

>>> src/ovn_div.sv
module ovn_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [31:0]           dividend,
  input  logic [15:0]           divisor,
  output ovn_pkg::ovn_div_stat_t stat,
  output logic [31:0]           quotient
);
  import ovn_pkg::*;

  logic        active;
  logic [4:0]  count;
  logic [15:0] rem;
  logic [31:0] dvd;
  logic [16:0] trial;
  logic        ge;
  logic [16:0] diff;
  logic        done;

  // restoring division, one quotient bit per cycle, msb first
  assign trial = {rem, dvd[31]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= ~start & active & (count == 5'd31);
      if (start) begin
        active <= 1'b1;
        count  <= '0;
      end else if (active) begin
        count <= count + 5'd1;
        if (count == 5'd31) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvd      <= dividend;
      quotient <= '0;
    end else if (active) begin
      rem      <= ge ? diff[15:0] : trial[15:0];
      dvd      <= {dvd[30:0], 1'b0};
      quotient <= {quotient[30:0], ge};
    end
  end

  // integer bits of the quotient come out first
  assign stat.done      = done;
  assign stat.int_valid = active & ~count[4];
  assign stat.int_bit   = ge;

endmodule

>>> src/ovn_phase.sv
module ovn_phase #(
  parameter int TABLE_SIZE = 256,
  parameter int AW         = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ovn_pkg::ovn_phase_ctrl_t ctrl,
  input  logic [15:0]             frac_in,
  output logic [AW-1:0]           idx,
  output logic [AW-1:0]           nxt,
  output logic [15:0]             frac
);
  import ovn_pkg::*;

  function automatic logic [AW-1:0] mod_step(input logic [AW-1:0] v, input logic b);
    logic [AW:0] t;
    t = {v, b};
    if (t >= (AW+1)'(TABLE_SIZE)) begin
      t = t - (AW+1)'(TABLE_SIZE);
    end
    return t[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctrl.clear) begin
      idx <= '0;
    end else if (ctrl.push) begin
      idx <= mod_step(idx, ctrl.push_bit);
    end else if (ctrl.advance) begin
      idx <= mod_step(idx, frac[15]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      frac <= frac_in;
    end else if (ctrl.advance) begin
      frac <= {frac[14:0], 1'b0};
    end
  end

  assign nxt = (idx == AW'(TABLE_SIZE - 1)) ? '0 : idx + AW'(1);

endmodule

>>> src/ovn_table.sv
module ovn_table #(
  parameter int TABLE_SIZE = 256,
  parameter int AW         = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
